>>> sv/orb_pkg.sv
`timescale 1ns / 1ps
// package: shared types and constants of the overwriting ring buffer
package orb_pkg;

    localparam int CNT_W = 8;

    localparam logic REQ_ENQUEUE = 1'b0;
    localparam logic REQ_DEQUEUE = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

endpackage

>>> sv/overwriting_ring_buffer_core.sv
`timescale 1ns / 1ps
// top level: ring buffer that drops its oldest entry when an enqueue finds it full
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  request | start, busy, i_req_type, i_data_in       | in (busy out)
//  result  | o_res_strobe, o_popped_value, ...        | out
//  config  | i_cfg_valid, o_cfg_ready, i_cfg_data     | in (o_cfg_ready out)
//
// the accept cycle updates pointers, writes the ram and starts the read of the
// new head; the next cycle takes the ram read data.
// the result strobe comes in the cycle after that, in which busy is already low.
// a capacity write empties the buffer. reset gives capacity DEPTH (at most 255).
// cfg ready is low while start is high, an item is in flight or its result shows.
// results cannot be held off; each is shown for exactly one cycle.
module overwriting_ring_buffer_core #(
    parameter int DEPTH      = 128,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_req_type,
    input  logic signed [DATA_WIDTH-1:0]  i_data_in,
    output logic                          o_res_strobe,
    output logic signed [DATA_WIDTH-1:0]  o_popped_value,
    output logic                          o_pop_was_empty,
    output logic                          o_overwrote_oldest,
    output logic signed [DATA_WIDTH-1:0]  o_oldest_value,
    output logic signed [DATA_WIDTH-1:0]  o_newest_value,
    output logic [orb_pkg::CNT_W-1:0]     o_fill_count,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [orb_pkg::CNT_W-1:0]     i_cfg_data
);

    import orb_pkg::*;

    localparam int AW      = $clog2(DEPTH);
    localparam int IW      = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
    localparam int CAP_MAX = (DEPTH < 255) ? DEPTH : 255;
    localparam logic [CNT_W-1:0]      CAP_RST   = CNT_W'(CAP_MAX);
    localparam logic [DATA_WIDTH-1:0] MINUS_ONE = {DATA_WIDTH{1'b1}};

    function automatic logic [AW-1:0] adv(input logic [AW-1:0] idx,
                                          input logic [CNT_W-1:0] cap);
        logic [IW-1:0] nxt;
        nxt = IW'(idx) + IW'(1);
        if (nxt >= IW'(cap)) begin
            return '0;
        end
        return nxt[AW-1:0];
    endfunction

    t_state r_state, n_state;
    logic [AW-1:0]         r_head, n_head;
    logic [AW-1:0]         r_tail, n_tail;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_cap, n_cap;
    logic                  r_strobe;
    logic [DATA_WIDTH-1:0] r_oldest;
    logic [DATA_WIDTH-1:0] r_newest;
    logic [DATA_WIDTH-1:0] r_data;
    logic                  r_fwd, n_fwd;
    logic [DATA_WIDTH-1:0] r_popped, n_popped;
    logic                  r_empty, n_empty;
    logic                  r_drop, n_drop;
    logic [DATA_WIDTH-1:0] r_out_oldest, r_out_newest;
    logic [DATA_WIDTH-1:0] n_oldest;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic                  accept;
    logic                  cfg_wr;
    logic                  is_enq;
    logic                  ram_we;

    assign accept      = start && (r_state == ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE) && !start && !r_strobe;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign is_enq      = (i_req_type == REQ_ENQUEUE);
    assign ram_we      = accept && is_enq;

    // capacity register saturation
    always_comb begin
        if (i_cfg_data == '0) begin
            n_cap = CNT_W'(1);
        end else if (IW'(i_cfg_data) > IW'(DEPTH)) begin
            n_cap = CNT_W'(DEPTH);
        end else begin
            n_cap = i_cfg_data;
        end
    end

    // pointer and count update for one item
    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_popped = MINUS_ONE;
        n_empty  = 1'b0;
        n_drop   = 1'b0;
        if (is_enq) begin
            if (r_count == r_cap) begin
                n_head = adv(r_head, r_cap);
                n_drop = 1'b1;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
            n_tail = adv(r_tail, r_cap);
        end else begin
            if (r_count == '0) begin
                n_empty = 1'b1;
            end else begin
                n_popped = r_oldest;
                n_head   = adv(r_head, r_cap);
                n_count  = r_count - CNT_W'(1);
            end
        end
        n_fwd = is_enq && (n_head == r_tail);
    end

    // state machine
    always_comb begin
        n_state = r_state;
        busy    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                busy    = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // head entry after the step, forwarded when the ram write hit it
    always_comb begin
        if (r_fwd) begin
            n_oldest = r_data;
        end else begin
            n_oldest = ram_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_cap    <= CAP_RST;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == ST_READ);
            if (cfg_wr) begin
                r_head  <= '0;
                r_tail  <= '0;
                r_count <= '0;
                r_cap   <= n_cap;
            end else if (accept) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_popped <= n_popped;
            r_empty  <= n_empty;
            r_drop   <= n_drop;
            r_data   <= i_data_in;
            r_fwd    <= n_fwd;
            if (is_enq) begin
                r_newest <= i_data_in;
            end
        end
        if (r_state == ST_READ) begin
            r_oldest <= n_oldest;
            if (r_count == '0) begin
                r_out_oldest <= MINUS_ONE;
                r_out_newest <= MINUS_ONE;
            end else begin
                r_out_oldest <= n_oldest;
                r_out_newest <= r_newest;
            end
        end
    end

    orb_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (i_data_in),
        .i_raddr (n_head),
        .o_rdata (ram_rdata)
    );

    assign o_res_strobe       = r_strobe;
    assign o_popped_value     = r_popped;
    assign o_pop_was_empty    = r_empty;
    assign o_overwrote_oldest = r_drop;
    assign o_oldest_value     = r_out_oldest;
    assign o_newest_value     = r_out_newest;
    assign o_fill_count       = r_count;

`ifndef NO_ASSERTIONS
    a_accept_then_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy ##1 o_res_strobe)
        else $error("accepted item did not produce a result two cycles later");

    a_count_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> (o_fill_count <= r_cap))
        else $error("fill count exceeds capacity");

    a_flags_exclusive : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> !(o_pop_was_empty && o_overwrote_oldest))
        else $error("empty pop and overwrite flagged together");

    a_drop_keeps_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_overwrote_oldest) |-> (o_fill_count == r_cap))
        else $error("overwrite reported while buffer not full");
`endif

endmodule

>>> sv/orb_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
module orb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> tb/tb_overwriting_ring_buffer_core.sv
`timescale 1ns / 1ps
// testbench: overwriting ring buffer core checked against a cycle-free occupancy model

typedef struct packed {
    logic signed [31:0] popped;
    logic               was_empty;
    logic               dropped;
    logic signed [31:0] oldest;
    logic signed [31:0] newest;
    logic [7:0]         fill;
} t_ring_result;

class ring_scoreboard;
    logic signed [31:0] words [128];
    int unsigned        head_idx;
    int unsigned        tail_idx;
    int unsigned        held;
    logic [7:0]         capacity;
    t_ring_result       awaited [$];
    int                 mismatches;
    int                 n_requests;
    int                 n_checked;
    int                 n_drops;
    int                 n_empty_pops;
    int                 n_cfg;

    function new();
        head_idx = 0;
        tail_idx = 0;
        held = 0;
        capacity = 8'd128;
        mismatches = 0;
        n_requests = 0;
        n_checked = 0;
        n_drops = 0;
        n_empty_pops = 0;
        n_cfg = 0;
    endfunction

    function int unsigned cap_in_use();
        if (capacity == 8'd0) return 1;
        if (capacity > 8'd128) return 128;
        return capacity;
    endfunction

    function int unsigned wrap_step(int unsigned idx, int unsigned cap);
        return (idx + 1 >= cap) ? 0 : idx + 1;
    endfunction

    function void set_capacity(logic [7:0] value);
        capacity = value;
        head_idx = 0;
        tail_idx = 0;
        held = 0;
        n_cfg++;
    endfunction

    task report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 40) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    function void note_request(logic req, logic signed [31:0] data);
        t_ring_result r;
        int unsigned  cap;
        int unsigned  last_idx;
        cap = cap_in_use();
        if (head_idx >= cap) head_idx = 0;
        if (tail_idx >= cap) tail_idx = 0;
        if (held > cap) held = cap;
        r.popped = -32'sd1;
        r.was_empty = 1'b0;
        r.dropped = 1'b0;
        r.oldest = -32'sd1;
        r.newest = -32'sd1;
        if (req == orb_pkg::REQ_ENQUEUE) begin
            if (held >= cap) begin
                head_idx = wrap_step(head_idx, cap);
                r.dropped = 1'b1;
                n_drops++;
            end else begin
                held++;
            end
            words[tail_idx] = data;
            tail_idx = wrap_step(tail_idx, cap);
        end else begin
            if (held == 0) begin
                r.was_empty = 1'b1;
                n_empty_pops++;
            end else begin
                r.popped = words[head_idx];
                head_idx = wrap_step(head_idx, cap);
                held--;
            end
        end
        if (held != 0) begin
            last_idx = (tail_idx == 0) ? cap - 1 : tail_idx - 1;
            r.oldest = words[head_idx];
            r.newest = words[last_idx];
        end
        r.fill = held[7:0];
        awaited.push_back(r);
        n_requests++;
    endfunction

    task check_result(t_ring_result got);
        t_ring_result exp;
        if (awaited.size() == 0) begin
            report_mismatch("result strobe with no item outstanding");
            return;
        end
        exp = awaited.pop_front();
        n_checked++;
        if (got.popped !== exp.popped)
            report_mismatch($sformatf("popped_value got %h exp %h", got.popped, exp.popped));
        if (got.was_empty !== exp.was_empty)
            report_mismatch($sformatf("pop_was_empty got %b exp %b",
                                      got.was_empty, exp.was_empty));
        if (got.dropped !== exp.dropped)
            report_mismatch($sformatf("overwrote_oldest got %b exp %b",
                                      got.dropped, exp.dropped));
        if (got.oldest !== exp.oldest)
            report_mismatch($sformatf("oldest_value got %h exp %h", got.oldest, exp.oldest));
        if (got.newest !== exp.newest)
            report_mismatch($sformatf("newest_value got %h exp %h", got.newest, exp.newest));
        if (got.fill !== exp.fill)
            report_mismatch($sformatf("fill_count got %0d exp %0d", got.fill, exp.fill));
    endtask
endclass

module tb_overwriting_ring_buffer_core;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_req_type;
    logic signed [31:0] i_data_in;
    logic               o_res_strobe;
    logic signed [31:0] o_popped_value;
    logic               o_pop_was_empty;
    logic               o_overwrote_oldest;
    logic signed [31:0] o_oldest_value;
    logic signed [31:0] o_newest_value;
    logic [7:0]         o_fill_count;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [7:0]         i_cfg_data;

    ring_scoreboard sb;

    overwriting_ring_buffer_core #(
        .DEPTH      (128),
        .DATA_WIDTH (32)
    ) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_req_type         (i_req_type),
        .i_data_in          (i_data_in),
        .o_res_strobe       (o_res_strobe),
        .o_popped_value     (o_popped_value),
        .o_pop_was_empty    (o_pop_was_empty),
        .o_overwrote_oldest (o_overwrote_oldest),
        .o_oldest_value     (o_oldest_value),
        .o_newest_value     (o_newest_value),
        .o_fill_count       (o_fill_count),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb_overwriting_ring_buffer_core: errors");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_res_strobe)
                sb.check_result({o_popped_value, o_pop_was_empty, o_overwrote_oldest,
                                 o_oldest_value, o_newest_value, o_fill_count});
            if (start && !busy)
                sb.note_request(i_req_type, i_data_in);
            if (i_cfg_valid && o_cfg_ready)
                sb.set_capacity(i_cfg_data);
        end
    end

    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_request(input logic req, input logic signed [31:0] data,
                                input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req_type <= req;
        i_data_in <= data;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [7:0] cap);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [7:0] cap, input int idle_pct);
        int n_items;
        int left;
        int run_len;
        int enq_pct;
        write_capacity(cap);
        n_items = (sb.cap_in_use() >= 128) ? 200 : 80;
        // fill to capacity plus zero to four more entries first, to reach the overwrite path
        left = n_items - int'(sb.cap_in_use()) - int'($urandom_range(0, 4));
        repeat (n_items - left) push_request(orb_pkg::REQ_ENQUEUE, pick_word(), idle_pct);
        while (left > 0) begin
            run_len = $urandom_range(10, 60);
            if (run_len > left) run_len = left;
            case ($urandom_range(3))
                0: enq_pct = 15;
                1: enq_pct = 50;
                2: enq_pct = 85;
                default: enq_pct = 100;
            endcase
            repeat (run_len)
                push_request(($urandom_range(99) < enq_pct) ? orb_pkg::REQ_ENQUEUE
                                                             : orb_pkg::REQ_DEQUEUE,
                             pick_word(), idle_pct);
            left -= run_len;
        end
    endtask

    logic [7:0] cap_plan [12];
    int         idle_plan [4];

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req_type = orb_pkg::REQ_ENQUEUE;
        i_data_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        cap_plan = '{8'd128, 8'd5, 8'd1, 8'd0, 8'd255, 8'd2,
                     8'd128, 8'd3, 8'd17, 8'd200, 8'd64, 8'd127};
        cap_plan[10] = 8'($urandom_range(1, 128));
        idle_plan = '{0, 55, 0, 37};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty pop, data extremes, drain to empty
        push_request(orb_pkg::REQ_DEQUEUE, pick_word(), 0);
        push_request(orb_pkg::REQ_ENQUEUE, 32'sh8000_0000, 0);
        push_request(orb_pkg::REQ_ENQUEUE, 32'sh7fff_ffff, 0);
        push_request(orb_pkg::REQ_ENQUEUE, 32'sd0, 0);
        push_request(orb_pkg::REQ_ENQUEUE, -32'sd1, 0);
        repeat (5) push_request(orb_pkg::REQ_DEQUEUE, pick_word(), 0);
        // single entry ring
        write_capacity(8'd1);
        push_request(orb_pkg::REQ_ENQUEUE, 32'sh1234_5678, 0);
        push_request(orb_pkg::REQ_ENQUEUE, 32'shedcb_a987, 0);
        repeat (2) push_request(orb_pkg::REQ_DEQUEUE, pick_word(), 0);
        // pointer wrap with overwrites
        write_capacity(8'd2);
        repeat (5) push_request(orb_pkg::REQ_ENQUEUE, $urandom, 0);
        repeat (3) push_request(orb_pkg::REQ_DEQUEUE, pick_word(), 0);
        // capacity zero acts as one, above depth saturates
        write_capacity(8'd0);
        repeat (2) push_request(orb_pkg::REQ_ENQUEUE, $urandom, 0);
        push_request(orb_pkg::REQ_DEQUEUE, pick_word(), 0);
        write_capacity(8'd255);
        push_request(orb_pkg::REQ_ENQUEUE, $urandom, 0);
        push_request(orb_pkg::REQ_DEQUEUE, pick_word(), 0);

        for (int p = 0; p < 12; p++) run_phase(cap_plan[p], idle_plan[p % 4]);

        drain_results();
        repeat (4) @(posedge i_clk);
        $display("covered %0d items over %0d capacity settings: %0d overwrites, %0d empty pops",
                 sb.n_requests, sb.n_cfg, sb.n_drops, sb.n_empty_pops);
        $display("%0d results checked, %0d mismatches", sb.n_checked, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("tb_overwriting_ring_buffer_core: clean");
        end else begin
            $display("tb_overwriting_ring_buffer_core: errors");
        end
        $finish;
    end

endmodule
